FILE: hdl/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg
// Shared constants, codes and the result record of the Pascal subset lexer.
// ----------------------------------------------------------------------------
package psl_pkg;

    // Identifier bytes kept for keyword matching, and width of the line counter.
    localparam int KEYWORD_MAX_LEN = 8;
    localparam int LINE_BITS       = 16;
    localparam int KW_IDX_W        = $clog2(KEYWORD_MAX_LEN);

    // Widths of the result fields.
    localparam int CODE_W = 5;
    localparam int LINE_W = 16;
    localparam int LEN_W  = 8;

    localparam logic [LEN_W-1:0] RUN_MAX = '1;

    // Lexer modes.
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_NUM   = 3'd2;
    localparam logic [2:0] MODE_LT    = 3'd3;
    localparam logic [2:0] MODE_GT    = 3'd4;
    localparam logic [2:0] MODE_COLON = 3'd5;

    // Token codes.
    localparam logic [CODE_W-1:0] TOK_NONE   = 5'd0;
    localparam logic [CODE_W-1:0] TOK_IDENT  = 5'd10;
    localparam logic [CODE_W-1:0] TOK_NUMBER = 5'd11;
    localparam logic [CODE_W-1:0] TOK_EQ     = 5'd12;
    localparam logic [CODE_W-1:0] TOK_NE     = 5'd13;
    localparam logic [CODE_W-1:0] TOK_LE     = 5'd14;
    localparam logic [CODE_W-1:0] TOK_LT     = 5'd15;
    localparam logic [CODE_W-1:0] TOK_GE     = 5'd16;
    localparam logic [CODE_W-1:0] TOK_GT     = 5'd17;
    localparam logic [CODE_W-1:0] TOK_MINUS  = 5'd18;
    localparam logic [CODE_W-1:0] TOK_STAR   = 5'd19;
    localparam logic [CODE_W-1:0] TOK_ASSIGN = 5'd20;
    localparam logic [CODE_W-1:0] TOK_LPAR   = 5'd21;
    localparam logic [CODE_W-1:0] TOK_RPAR   = 5'd22;
    localparam logic [CODE_W-1:0] TOK_SEMI   = 5'd23;
    localparam logic [CODE_W-1:0] TOK_EOL    = 5'd24;
    localparam logic [CODE_W-1:0] TOK_EOF    = 5'd25;

    // Error codes.
    localparam logic ERR_ILLEGAL = 1'b0;
    localparam logic ERR_COLON   = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_LPAR  = 8'd40;
    localparam logic [7:0] CH_RPAR  = 8'd41;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_LT    = 8'd60;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_GT    = 8'd62;

    // Keyword table. Text is right-justified: the first letter sits highest.
    localparam int KW_COUNT = 9;
    localparam int KW_CHARS = 8;
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        64'("begin"), 64'("end"), 64'("integer"), 64'("if"), 64'("then"),
        64'("else"), 64'("function"), 64'("read"), 64'("write")
    };
    localparam int KW_LEN [KW_COUNT] = '{5, 3, 7, 2, 4, 4, 8, 4, 5};

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic              is_error;
        logic [CODE_W-1:0] token_code;
        logic              error_code;
        logic [LINE_W-1:0] line_number;
        logic [LEN_W-1:0]  token_length;
        logic [7:0]        bad_char;
        logic              last_of_run;
    } t_result;

endpackage

FILE: hdl/psl_lex_core.sv
// ----------------------------------------------------------------------------
// psl_lex_core
// Lexer state and next-state logic: turns one registered byte into up to two
// results and updates mode, run length, line count and the keyword buffer.
// ----------------------------------------------------------------------------
module psl_lex_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_char,
    input  logic              i_eoi,
    output psl_pkg::t_result  o_res0,
    output psl_pkg::t_result  o_res1,
    output logic [1:0]        o_cnt
);
    import psl_pkg::*;

    logic [2:0]           r_mode, n_mode;
    logic [LEN_W-1:0]     r_run, n_run;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [7:0]           r_buf [KEYWORD_MAX_LEN];

    logic                 is_letter, is_digit;
    logic [KW_COUNT-1:0]  kw_hit;
    logic [CODE_W-1:0]    kw_code;
    logic                 kw_any;
    t_result              word_res;

    // Outcome of a byte that starts a new token, in idle mode or after a flush.
    logic                 f_emit, f_grow, f_line_inc;
    t_result              f_res;
    logic [2:0]           f_mode;
    logic [LEN_W-1:0]     f_run;

    logic                 p_emit, s_emit, use_fresh, grow_cur;
    t_result              p_res, s_res;
    logic                 wr_en;
    logic [KW_IDX_W-1:0]  wr_idx;
    logic [LINE_W-1:0]    line_out;

    function automatic t_result mk_res(input logic err, input logic [CODE_W-1:0] code,
                                       input logic ecode, input logic [LEN_W-1:0] len,
                                       input logic [7:0] bad);
        t_result r;
        r              = '0;
        r.is_error     = err;
        r.token_code   = code;
        r.error_code   = ecode;
        r.token_length = len;
        r.bad_char     = bad;
        return r;
    endfunction

    assign is_letter = (i_char >= 8'd65 && i_char <= 8'd90) ||
                       (i_char >= 8'd97 && i_char <= 8'd122);
    assign is_digit  = (i_char > 8'd47) && (i_char < 8'd58);
    assign line_out  = LINE_W'(r_line);

    // Parallel keyword compare over the stored prefix.
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            kw_hit[k] = (r_run == LEN_W'(KW_LEN[k]));
            for (int j = 0; j < KW_CHARS; j++) begin
                if (j < KW_LEN[k]) begin
                    if (r_buf[j] != KW_TEXT[k][8*(KW_LEN[k]-1-j) +: 8]) begin
                        kw_hit[k] = 1'b0;
                    end
                end
            end
        end
        kw_code = TOK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (kw_hit[k]) begin
                kw_code = CODE_W'(k + 1);
            end
        end
        kw_any = |kw_hit;
    end

    always_comb begin
        if (r_mode == MODE_NUM) begin
            word_res = mk_res(1'b0, TOK_NUMBER, 1'b0, r_run, 8'd0);
        end else if (kw_any) begin
            word_res = mk_res(1'b0, kw_code, 1'b0, '0, 8'd0);
        end else begin
            word_res = mk_res(1'b0, TOK_IDENT, 1'b0, r_run, 8'd0);
        end
    end

    // A byte handled as the start of a new token.
    always_comb begin
        f_emit     = 1'b0;
        f_res      = '0;
        f_mode     = MODE_IDLE;
        f_run      = '0;
        f_grow     = 1'b0;
        f_line_inc = 1'b0;
        if (is_letter) begin
            f_mode = MODE_IDENT;
            f_run  = LEN_W'(1);
            f_grow = 1'b1;
        end else if (is_digit) begin
            f_mode = MODE_NUM;
            f_run  = LEN_W'(1);
            f_grow = 1'b1;
        end else begin
            case (i_char)
                CH_SPACE: f_emit = 1'b0;
                CH_EQ:    begin f_emit = 1'b1; f_res = mk_res(1'b0, TOK_EQ, 1'b0, '0, 8'd0); end
                CH_MINUS: begin f_emit = 1'b1; f_res = mk_res(1'b0, TOK_MINUS, 1'b0, '0, 8'd0); end
                CH_STAR:  begin f_emit = 1'b1; f_res = mk_res(1'b0, TOK_STAR, 1'b0, '0, 8'd0); end
                CH_LPAR:  begin f_emit = 1'b1; f_res = mk_res(1'b0, TOK_LPAR, 1'b0, '0, 8'd0); end
                CH_RPAR:  begin f_emit = 1'b1; f_res = mk_res(1'b0, TOK_RPAR, 1'b0, '0, 8'd0); end
                CH_SEMI:  begin f_emit = 1'b1; f_res = mk_res(1'b0, TOK_SEMI, 1'b0, '0, 8'd0); end
                CH_LT:    f_mode = MODE_LT;
                CH_GT:    f_mode = MODE_GT;
                CH_COLON: f_mode = MODE_COLON;
                CH_NL: begin
                    f_emit     = 1'b1;
                    f_res      = mk_res(1'b0, TOK_EOL, 1'b0, '0, 8'd0);
                    f_line_inc = 1'b1;
                end
                default: begin
                    f_emit = 1'b1;
                    f_res  = mk_res(1'b1, TOK_NONE, ERR_ILLEGAL, '0, i_char);
                end
            endcase
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_run     = r_run;
        n_line    = r_line;
        p_emit    = 1'b0;
        p_res     = '0;
        s_emit    = 1'b0;
        s_res     = '0;
        use_fresh = 1'b0;
        grow_cur  = 1'b0;
        wr_en     = 1'b0;
        wr_idx    = '0;

        if (i_eoi) begin
            case (r_mode)
                MODE_IDENT, MODE_NUM: begin p_emit = 1'b1; p_res = word_res; end
                MODE_LT:    begin p_emit = 1'b1; p_res = mk_res(1'b0, TOK_LT, 1'b0, '0, 8'd0); end
                MODE_GT:    begin p_emit = 1'b1; p_res = mk_res(1'b0, TOK_GT, 1'b0, '0, 8'd0); end
                MODE_COLON: begin p_emit = 1'b1; p_res = mk_res(1'b1, TOK_NONE, ERR_COLON, '0, 8'd0); end
                default:    p_emit = 1'b0;
            endcase
            s_emit = 1'b1;
            s_res  = mk_res(1'b0, TOK_EOF, 1'b0, '0, 8'd0);
            n_mode = MODE_IDLE;
            n_run  = '0;
        end else begin
            case (r_mode)
                MODE_IDENT: begin
                    if (is_letter || is_digit) begin
                        grow_cur = 1'b1;
                    end else begin
                        p_emit    = 1'b1;
                        p_res     = word_res;
                        use_fresh = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_digit) begin
                        grow_cur = 1'b1;
                    end else begin
                        p_emit    = 1'b1;
                        p_res     = word_res;
                        use_fresh = 1'b1;
                    end
                end
                MODE_LT: begin
                    p_emit = 1'b1;
                    n_mode = MODE_IDLE;
                    if (i_char == CH_EQ) begin
                        p_res = mk_res(1'b0, TOK_LE, 1'b0, '0, 8'd0);
                    end else if (i_char == CH_GT) begin
                        p_res = mk_res(1'b0, TOK_NE, 1'b0, '0, 8'd0);
                    end else begin
                        p_res     = mk_res(1'b0, TOK_LT, 1'b0, '0, 8'd0);
                        use_fresh = 1'b1;
                    end
                end
                MODE_GT: begin
                    p_emit = 1'b1;
                    n_mode = MODE_IDLE;
                    if (i_char == CH_EQ) begin
                        p_res = mk_res(1'b0, TOK_GE, 1'b0, '0, 8'd0);
                    end else begin
                        p_res     = mk_res(1'b0, TOK_GT, 1'b0, '0, 8'd0);
                        use_fresh = 1'b1;
                    end
                end
                MODE_COLON: begin
                    p_emit = 1'b1;
                    n_mode = MODE_IDLE;
                    if (i_char == CH_EQ) begin
                        p_res = mk_res(1'b0, TOK_ASSIGN, 1'b0, '0, 8'd0);
                    end else begin
                        p_res     = mk_res(1'b1, TOK_NONE, ERR_COLON, '0, 8'd0);
                        use_fresh = 1'b1;
                    end
                end
                default: use_fresh = 1'b1;
            endcase
        end

        if (grow_cur) begin
            wr_en  = (r_run < LEN_W'(KEYWORD_MAX_LEN));
            wr_idx = r_run[KW_IDX_W-1:0];
            if (r_run != RUN_MAX) begin
                n_run = r_run + LEN_W'(1);
            end
        end

        if (use_fresh) begin
            s_emit = f_emit;
            s_res  = f_res;
            n_mode = f_mode;
            n_run  = f_run;
            wr_en  = f_grow;
            wr_idx = '0;
            if (f_line_inc && (r_line != '1)) begin
                n_line = r_line + LINE_BITS'(1);
            end
        end
    end

    // Pack the results in order; every result of an item carries the line it
    // started on, since the count only moves after the end-of-line token.
    always_comb begin
        o_res0             = p_emit ? p_res : s_res;
        o_res0.line_number = line_out;
        o_res0.last_of_run = !(p_emit && s_emit);
        o_res1             = s_res;
        o_res1.line_number = line_out;
        o_res1.last_of_run = 1'b1;
        o_cnt              = {1'b0, p_emit} + {1'b0, s_emit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_run  <= '0;
            r_line <= LINE_BITS'(1);
        end else if (i_take) begin
            r_mode <= n_mode;
            r_run  <= n_run;
            r_line <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && wr_en) begin
            r_buf[wr_idx] <= i_char;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_eoi) |-> (o_cnt != 2'd0))
        else $error("end marker produced no end-of-file result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_eoi) |=> (r_mode == MODE_IDLE && r_run == '0))
        else $error("lexer not idle after end marker");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDENT || r_mode == MODE_NUM) |-> (r_run != '0))
        else $error("word mode with empty run");

endmodule

FILE: hdl/psl_res_fifo.sv
// ----------------------------------------------------------------------------
// psl_res_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module psl_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  psl_pkg::t_result  i_res0,
    input  psl_pkg::t_result  i_res1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output psl_pkg::t_result  o_head
);
    import psl_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count, n_count;
    logic [FIFO_PTR_W-1:0]  wr_ptr_next;
    logic                   pop;

    assign pop         = o_valid && i_ready;
    assign o_valid     = (r_count != '0);
    assign o_room      = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_head      = r_mem[r_rd_ptr];
    assign wr_ptr_next = r_wr_ptr + FIFO_PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push_cnt);
        n_rd_ptr = pop ? (r_rd_ptr + FIFO_PTR_W'(1)) : r_rd_ptr;
        n_count  = r_count + FIFO_CNT_W'(i_push_cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr_next] <= i_res1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("results pushed without room for two");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) + FIFO_CNT_W'($past(i_push_cnt))
                             - FIFO_CNT_W'($past(pop))))
        else $error("result queue count out of step");

endmodule

FILE: hdl/pascal_subset_lexer.sv
// ----------------------------------------------------------------------------
// pascal_subset_lexer
// Tokenizer for a small Pascal subset: one source byte or end marker in,
// token codes and error reports out.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_ready    i_char_byte, i_end_of_input
//   result   out        o_valid / i_ready    o_is_error .. o_last_of_run
//
// A byte is registered on acceptance and lexed from that register when the
// result queue has room; its results are written into the queue as it is lexed.
// One byte per cycle is taken while the queue has room; an item that causes
// two results is paced by the single read port of the four-entry result queue.
// The lexer stalls while the queue holds more than two results.
// Reset returns to idle mode on line one; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pascal_subset_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_error,
    output logic [4:0]  o_token_code,
    output logic        o_error_code,
    output logic [15:0] o_line_number,
    output logic [7:0]  o_token_length,
    output logic [7:0]  o_bad_char,
    output logic        o_last_of_run
);
    import psl_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eoi;
    logic       take, room;
    t_result    res0, res1, head;
    logic [1:0] res_cnt;

    assign take    = r_in_valid && room;
    assign o_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_char <= i_char_byte;
            r_in_eoi  <= i_end_of_input;
        end
    end

    psl_lex_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (r_in_char),
        .i_eoi   (r_in_eoi),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_cnt   (res_cnt)
    );

    psl_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (take ? res_cnt : 2'd0),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_room     (room),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_head     (head)
    );

    assign o_is_error     = head.is_error;
    assign o_token_code   = head.token_code;
    assign o_error_code   = head.error_code;
    assign o_line_number  = head.line_number;
    assign o_token_length = head.token_length;
    assign o_bad_char     = head.bad_char;
    assign o_last_of_run  = head.last_of_run;

endmodule

FILE: tb/sv/pascal_subset_lexer_tb.sv
// ----------------------------------------------------------------------------
// pascal_subset_lexer_tb
// Self-checking bench for the Pascal subset lexer. A short directed table
// and a long stream of mostly well-formed random source text are sent
// through the byte channel, closed by an end marker. Every result transfer
// is checked, field by field, against the expected result of a directed row
// or against a behavioral lexer that runs on each accepted byte.
// ----------------------------------------------------------------------------
module pascal_subset_lexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psl_pkg::*;

    // Keyword token codes.
    localparam logic [CODE_W-1:0] TOK_BEGIN    = 5'd1;
    localparam logic [CODE_W-1:0] TOK_END      = 5'd2;
    localparam logic [CODE_W-1:0] TOK_INTEGER  = 5'd3;
    localparam logic [CODE_W-1:0] TOK_IF       = 5'd4;
    localparam logic [CODE_W-1:0] TOK_THEN     = 5'd5;
    localparam logic [CODE_W-1:0] TOK_ELSE     = 5'd6;
    localparam logic [CODE_W-1:0] TOK_FUNCTION = 5'd7;
    localparam logic [CODE_W-1:0] TOK_READ     = 5'd8;
    localparam logic [CODE_W-1:0] TOK_WRITE    = 5'd9;

    localparam logic [CODE_W-1:0] KW_TOKENS [9] = '{TOK_BEGIN, TOK_END, TOK_INTEGER,
        TOK_IF, TOK_THEN, TOK_ELSE, TOK_FUNCTION, TOK_READ, TOK_WRITE};

    localparam int RANDOM_ITEMS = 1780;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        bit         typed;
        t_result    want;
    } t_src_item;

    string kw_words [9] = '{"begin", "end", "integer", "if", "then", "else",
                            "function", "read", "write"};
    string op_words [13] = '{"=", "<>", "<=", "<", ">=", ">", "-", "*", ":=", ":",
                             "(", ")", ";"};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_char_byte = 8'd0;
    logic        i_end_of_input = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_is_error;
    logic [4:0]  o_token_code;
    logic        o_error_code;
    logic [15:0] o_line_number;
    logic [7:0]  o_token_length;
    logic [7:0]  o_bad_char;
    logic        o_last_of_run;

    pascal_subset_lexer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_byte    (i_char_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_is_error     (o_is_error),
        .o_token_code   (o_token_code),
        .o_error_code   (o_error_code),
        .o_line_number  (o_line_number),
        .o_token_length (o_token_length),
        .o_bad_char     (o_bad_char),
        .o_last_of_run  (o_last_of_run)
    );

    // Lexer state as seen by the bench.
    logic [2:0]           lx_mode = MODE_IDLE;
    logic [LINE_BITS-1:0] lx_line = LINE_BITS'(1);
    logic [LEN_W-1:0]     lx_run = '0;
    logic [7:0]           lx_word [KEYWORD_MAX_LEN];

    t_result   step_tokens [$];
    t_result   tokens_due [$];
    t_src_item source_q [$];
    t_src_item dir_rows [25];

    bit        in_taken = 1'b0;
    bit        steady = 1'b0;
    bit        cur_typed = 1'b0;
    t_result   cur_want;

    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int kw_seen = 0;
    int err_seen = 0;
    int sat_len_seen = 0;

    // ------------------------------------------------------------------
    // Behavioral lexer
    // ------------------------------------------------------------------
    function automatic void lex_emit(logic err, logic [CODE_W-1:0] code, logic ecode,
                                     logic [LEN_W-1:0] len, logic [7:0] bad);
        t_result r;
        r.is_error     = err;
        r.token_code   = code;
        r.error_code   = ecode;
        r.line_number  = lx_line[LINE_W-1:0];
        r.token_length = len;
        r.bad_char     = bad;
        r.last_of_run  = 1'b0;
        step_tokens.push_back(r);
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void grow_word(logic [7:0] c);
        if (lx_run < KEYWORD_MAX_LEN) lx_word[lx_run[KW_IDX_W-1:0]] = c;
        if (lx_run != RUN_MAX) lx_run = lx_run + 1'b1;
    endfunction

    function automatic void flush_word();
        bit found;
        bit same;
        found = 1'b0;
        if (lx_mode == MODE_NUM) begin
            lex_emit(1'b0, TOK_NUMBER, ERR_ILLEGAL, lx_run, 8'd0);
        end else begin
            for (int k = 0; k < 9; k++) begin
                if (!found && lx_run == kw_words[k].len() && lx_run <= KEYWORD_MAX_LEN) begin
                    same = 1'b1;
                    for (int i = 0; i < kw_words[k].len(); i++)
                        if (lx_word[i] != kw_words[k][i]) same = 1'b0;
                    if (same) begin
                        found = 1'b1;
                        lex_emit(1'b0, KW_TOKENS[k], ERR_ILLEGAL, '0, 8'd0);
                    end
                end
            end
            if (!found) lex_emit(1'b0, TOK_IDENT, ERR_ILLEGAL, lx_run, 8'd0);
        end
        lx_run  = '0;
        lx_mode = MODE_IDLE;
    endfunction

    function automatic void fresh_byte(logic [7:0] c);
        lx_mode = MODE_IDLE;
        lx_run  = '0;
        if (c == CH_SPACE) begin
            return;
        end else if (is_letter(c)) begin
            lx_mode = MODE_IDENT;
            grow_word(c);
        end else if (is_digit(c)) begin
            lx_mode = MODE_NUM;
            grow_word(c);
        end else begin
            case (c)
                CH_EQ:    lex_emit(1'b0, TOK_EQ, ERR_ILLEGAL, '0, 8'd0);
                CH_MINUS: lex_emit(1'b0, TOK_MINUS, ERR_ILLEGAL, '0, 8'd0);
                CH_STAR:  lex_emit(1'b0, TOK_STAR, ERR_ILLEGAL, '0, 8'd0);
                CH_LPAR:  lex_emit(1'b0, TOK_LPAR, ERR_ILLEGAL, '0, 8'd0);
                CH_RPAR:  lex_emit(1'b0, TOK_RPAR, ERR_ILLEGAL, '0, 8'd0);
                CH_SEMI:  lex_emit(1'b0, TOK_SEMI, ERR_ILLEGAL, '0, 8'd0);
                CH_LT:    lx_mode = MODE_LT;
                CH_GT:    lx_mode = MODE_GT;
                CH_COLON: lx_mode = MODE_COLON;
                CH_NL: begin
                    // The end of line token carries the line it closes.
                    lex_emit(1'b0, TOK_EOL, ERR_ILLEGAL, '0, 8'd0);
                    if (lx_line != '1) lx_line = lx_line + 1'b1;
                end
                default:  lex_emit(1'b1, TOK_NONE, ERR_ILLEGAL, '0, c);
            endcase
        end
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic eoi);
        t_result r;
        step_tokens.delete();
        if (eoi) begin
            case (lx_mode)
                MODE_IDENT, MODE_NUM: flush_word();
                MODE_LT:    lex_emit(1'b0, TOK_LT, ERR_ILLEGAL, '0, 8'd0);
                MODE_GT:    lex_emit(1'b0, TOK_GT, ERR_ILLEGAL, '0, 8'd0);
                MODE_COLON: lex_emit(1'b1, TOK_NONE, ERR_COLON, '0, 8'd0);
                default: ;
            endcase
            lex_emit(1'b0, TOK_EOF, ERR_ILLEGAL, '0, 8'd0);
            lx_mode = MODE_IDLE;
            lx_run  = '0;
        end else begin
            case (lx_mode)
                MODE_IDENT: begin
                    if (is_letter(c) || is_digit(c)) grow_word(c);
                    else begin flush_word(); fresh_byte(c); end
                end
                MODE_NUM: begin
                    if (is_digit(c)) grow_word(c);
                    else begin flush_word(); fresh_byte(c); end
                end
                MODE_LT: begin
                    lx_mode = MODE_IDLE;
                    if (c == CH_EQ) lex_emit(1'b0, TOK_LE, ERR_ILLEGAL, '0, 8'd0);
                    else if (c == CH_GT) lex_emit(1'b0, TOK_NE, ERR_ILLEGAL, '0, 8'd0);
                    else begin
                        lex_emit(1'b0, TOK_LT, ERR_ILLEGAL, '0, 8'd0);
                        fresh_byte(c);
                    end
                end
                MODE_GT: begin
                    lx_mode = MODE_IDLE;
                    if (c == CH_EQ) lex_emit(1'b0, TOK_GE, ERR_ILLEGAL, '0, 8'd0);
                    else begin
                        lex_emit(1'b0, TOK_GT, ERR_ILLEGAL, '0, 8'd0);
                        fresh_byte(c);
                    end
                end
                MODE_COLON: begin
                    lx_mode = MODE_IDLE;
                    if (c == CH_EQ) lex_emit(1'b0, TOK_ASSIGN, ERR_ILLEGAL, '0, 8'd0);
                    else begin
                        lex_emit(1'b1, TOK_NONE, ERR_COLON, '0, 8'd0);
                        fresh_byte(c);
                    end
                end
                default: fresh_byte(c);
            endcase
        end
        if (step_tokens.size() > 0) begin
            r = step_tokens.pop_back();
            r.last_of_run = 1'b1;
            step_tokens.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Table rows and source text
    // ------------------------------------------------------------------
    function automatic t_src_item row(logic [7:0] ch);
        t_src_item it;
        it.ch    = ch;
        it.eoi   = 1'b0;
        it.typed = 1'b0;
        it.want  = '0;
        return it;
    endfunction

    function automatic t_src_item row_eof(logic [7:0] ch);
        t_src_item it;
        it     = row(ch);
        it.eoi = 1'b1;
        return it;
    endfunction

    function automatic t_src_item row_tok(logic [7:0] ch, logic [CODE_W-1:0] code,
                                          logic [LINE_W-1:0] line);
        t_src_item it;
        it                  = row(ch);
        it.typed            = 1'b1;
        it.want.token_code  = code;
        it.want.line_number = line;
        it.want.last_of_run = 1'b1;
        return it;
    endfunction

    function automatic t_src_item row_bad(logic [7:0] ch, logic [LINE_W-1:0] line);
        t_src_item it;
        it                  = row_tok(ch, TOK_NONE, line);
        it.want.is_error    = 1'b1;
        it.want.error_code  = ERR_ILLEGAL;
        it.want.bad_char    = ch;
        return it;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) source_q.push_back(row(s[i]));
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(1) ? "a" : "A") + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(9));
    endfunction

    // Mostly well-formed lexemes with random content; a share of noise bytes
    // and broken keywords keeps the error paths busy.
    task automatic make_source(int count);
        string w;
        int    len;
        int    pick;
        // Bytes next to the letter and digit ranges, plus control and high bytes.
        logic [7:0] border_bytes [11] = '{8'd47, 8'd64, 8'd91, 8'd96, 8'd123, 8'd127,
                                          8'd128, 8'd9, 8'd13, 8'd0, 8'd255};
        while (source_q.size() < count) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                w = kw_words[$urandom_range(8)];
                case ($urandom_range(9))
                    0: w[0] = w[0] - 8'd32;
                    1: w = w.substr(0, w.len() - 2);
                    2: w = {w, "s"};
                    3: w = {w, "7"};
                    default: ;
                endcase
                push_text(w);
            end else if (pick < 40) begin
                len = ($urandom_range(59) == 0) ? $urandom_range(250, 300)
                                                : $urandom_range(1, 12);
                source_q.push_back(row(rand_letter()));
                for (int i = 1; i < len; i++)
                    source_q.push_back(row($urandom_range(2) ? rand_letter() : rand_digit()));
            end else if (pick < 52) begin
                len = ($urandom_range(79) == 0) ? $urandom_range(255, 262)
                                                : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) source_q.push_back(row(rand_digit()));
            end else if (pick < 72) begin
                push_text(op_words[$urandom_range(12)]);
            end else if (pick < 80) begin
                source_q.push_back(row(CH_NL));
            end else if (pick < 83) begin
                source_q.push_back(row_eof(8'($urandom_range(255))));
            end else if (pick < 90) begin
                if ($urandom_range(1)) source_q.push_back(row(border_bytes[$urandom_range(10)]));
                else source_q.push_back(row(8'($urandom_range(255))));
            end else begin
                repeat ($urandom_range(1, 3)) source_q.push_back(row(CH_SPACE));
            end
            // Adjacent lexemes exercise the flush of a pending token.
            if ($urandom_range(1)) source_q.push_back(row(CH_SPACE));
        end
    endtask

    // ------------------------------------------------------------------
    // Byte channel driver
    // ------------------------------------------------------------------
    task automatic send_item(t_src_item it);
        while (!steady && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_typed = it.typed;
        cur_want  = it.want;
        i_valid        <= 1'b1;
        i_char_byte    <= it.ch;
        i_end_of_input <= it.eoi;
        do @(negedge i_clk); while (!in_taken);
        items_sent++;
    endtask

    task automatic send_source();
        for (int i = 0; i < source_q.size(); i++) begin
            steady = (i >= 600 && i < 900);
            send_item(source_q[i]);
        end
        steady = 1'b0;
        source_q.delete();
    endtask

    function automatic string show(t_result r);
        return $sformatf("err=%0d code=%0d ecode=%0d line=%0d len=%0d bad=%0d last=%0d",
                         r.is_error, r.token_code, r.error_code, r.line_number,
                         r.token_length, r.bad_char, r.last_of_run);
    endfunction

    function automatic string diff_fields(t_result w, t_result g);
        string s;
        s = "";
        if (w.is_error !== g.is_error)         s = {s, " is_error"};
        if (w.token_code !== g.token_code)     s = {s, " token_code"};
        if (w.error_code !== g.error_code)     s = {s, " error_code"};
        if (w.line_number !== g.line_number)   s = {s, " line_number"};
        if (w.token_length !== g.token_length) s = {s, " token_length"};
        if (w.bad_char !== g.bad_char)         s = {s, " bad_char"};
        if (w.last_of_run !== g.last_of_run)   s = {s, " last_of_run"};
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Clock, sink and monitor
    // ------------------------------------------------------------------
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_ready <= i_rst_n && (steady || $urandom_range(99) >= 30);
    end

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        string   bad_fields;
        in_taken = i_rst_n && i_valid && o_ready;
        if (in_taken) begin
            predict_tokens(i_char_byte, i_end_of_input);
            if (cur_typed) tokens_due.push_back(cur_want);
            else foreach (step_tokens[k]) tokens_due.push_back(step_tokens[k]);
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_is_error, o_token_code, o_error_code, o_line_number,
                   o_token_length, o_bad_char, o_last_of_run};
            results_seen++;
            if (tokens_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("Result transfer with none expected: %s", show(got));
            end else begin
                want = tokens_due.pop_front();
                bad_fields = diff_fields(want, got);
                if (bad_fields != "") begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("Mismatch on%s\n  expected %s\n  actual   %s",
                                 bad_fields, show(want), show(got));
                end
                if (!want.is_error && want.token_code >= TOK_BEGIN &&
                    want.token_code <= TOK_WRITE) kw_seen++;
                if (want.is_error) err_seen++;
                if (want.token_length == RUN_MAX) sat_len_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        dir_rows = '{
            row_tok(CH_EQ, TOK_EQ, LINE_W'(1)), row_bad(8'hFF, LINE_W'(1)),
            row_bad(8'h00, LINE_W'(1)),
            row(CH_SPACE),
            row(CH_LT), row(CH_GT), row(CH_EQ),           // <>  then =
            row(CH_LT), row(CH_EQ),                       // <=
            row(CH_LT), row(CH_GT),                       // <>
            row(CH_COLON), row("z"), row("9"), row(CH_NL), // lone colon, ident, newline
            row(CH_COLON), row(CH_EQ),                    // :=
            row(CH_LPAR), row(CH_RPAR), row(CH_SEMI), row(CH_MINUS), row(CH_STAR),
            row_bad(8'h09, LINE_W'(2)),                   // tab is not a space
            row(CH_COLON), row_eof(8'hFF)                 // colon pending at end
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) send_item(dir_rows[i]);

        make_source(RANDOM_ITEMS);
        source_q.push_back(row_eof(8'h00));
        send_source();
        i_valid <= 1'b0;

        while (tokens_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (tokens_due.size() != 0) fail_count++;

        $display("Lexed %0d source items into %0d checked results.", items_sent, results_seen);
        $display("Keywords %0d, error reports %0d, saturated lengths %0d, final line %0d.",
                 kw_seen, err_seen, sat_len_seen, lx_line);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
